FILE: rtl/ple_pkg.sv
// Shared constants, codes, types and helpers of the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

   // Sizes
   localparam int CAPACITY = 16;
   localparam int SLOT_W   = $clog2(CAPACITY);
   localparam int LEN_W    = 5;
   localparam int POS_W    = 5;
   localparam int CMD_W    = 2;
   localparam int STAT_W   = 2;
   localparam int DATA_W   = 32;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_FREE,
      ST_INS_TAKE,
      ST_WALK,
      ST_INS_LINK,
      ST_INS_FIX,
      ST_DEL_HEAD,
      ST_DEL_NEXT,
      ST_DEL_UNLINK,
      ST_DEL_FREE,
      ST_RD_DATA,
      ST_RESPOND
   } state_type;

   // Write port of the link memory
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [SLOT_W-1:0] data;
   } link_wr_type;

   // Write port of the value memory
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [DATA_W-1:0] data;
   } value_wr_type;

   // Link held by a slot after reset: the following slot, wrapping at the end
   function automatic logic [SLOT_W-1:0] reset_link(input logic [SLOT_W-1:0] slot);
      logic [SLOT_W-1:0] res;
      if (slot == SLOT_W'(CAPACITY - 1)) begin
         res = '0;
      end else begin
         res = slot + SLOT_W'(1);
      end
      return res;
   endfunction

endpackage

FILE: rtl/ple_if.sv
// Request and response channel interfaces of the positional list engine.
`timescale 1ns / 1ps

interface ple_req_if import ple_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         cmd;
   logic [POS_W-1:0]         position;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, cmd, position, value, input ready);
   modport sink   (input valid, cmd, position, value, output ready);
endinterface

interface ple_rsp_if import ple_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic signed [DATA_W-1:0] read_value;
   logic [LEN_W-1:0]         length;

   modport source (output valid, status, read_value, length, input ready);
   modport sink   (input valid, status, read_value, length, output ready);
endinterface

FILE: rtl/ple_link_ram.sv
// Link memory: one read and one write port, registered read, reset chain by valid bits.
`timescale 1ns / 1ps

module ple_link_ram import ple_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [SLOT_W-1:0] rd_addr,
   output logic [SLOT_W-1:0] rd_data,
   input  link_wr_type       wr
);

   logic [SLOT_W-1:0]   mem_ff [CAPACITY];
   logic [CAPACITY-1:0] written_ff;
   logic [SLOT_W-1:0]   q_ff;
   logic [SLOT_W-1:0]   addr_ff;
   logic                hit_ff;

   // Write the array and register the read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      q_ff    <= mem_ff[rd_addr];
      addr_ff <= rd_addr;
   end

   // Track which slots hold a written link
   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         hit_ff     <= 1'b0;
      end else begin
         if (wr.en) begin
            written_ff[wr.addr] <= 1'b1;
         end
         hit_ff <= written_ff[rd_addr];
      end
   end

   // Unwritten slots read as their place on the initial free chain
   assign rd_data = hit_ff ? q_ff : reset_link(addr_ff);

endmodule

FILE: rtl/ple_value_ram.sv
// Value memory: one read and one write port, registered read, no reset.
`timescale 1ns / 1ps

module ple_value_ram import ple_pkg::*; (
   input  logic              clock,
   input  logic [SLOT_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  value_wr_type      wr
);

   logic [DATA_W-1:0] mem_ff [CAPACITY];
   logic [DATA_W-1:0] q_ff;

   // Write the array and register the read
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      q_ff <= mem_ff[rd_addr];
   end

   assign rd_data = q_ff;

endmodule

FILE: rtl/ple_ctrl.sv
// Sequencer: checks each request, walks the links and rewrites them, holds the response.
`timescale 1ns / 1ps

module ple_ctrl import ple_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request side
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [CMD_W-1:0]  req_cmd,
   input  logic [POS_W-1:0]  req_position,
   input  logic [DATA_W-1:0] req_value,
   // response side
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [STAT_W-1:0] rsp_status,
   output logic [DATA_W-1:0] rsp_read_value,
   output logic [LEN_W-1:0]  rsp_length,
   // memories
   output logic [SLOT_W-1:0] link_rd_addr,
   input  logic [SLOT_W-1:0] link_rd_data,
   output link_wr_type       link_wr,
   output logic [SLOT_W-1:0] value_rd_addr,
   input  logic [DATA_W-1:0] value_rd_data,
   output value_wr_type      value_wr
);

   state_type         state_ff, state_in;
   logic [CMD_W-1:0]  cmd_ff, cmd_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [STAT_W-1:0] status_ff, status_in;
   logic [DATA_W-1:0] rdv_ff, rdv_in;
   logic [SLOT_W-1:0] first_ff, first_in;
   logic [SLOT_W-1:0] free_ff, free_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] s_ff, s_in;
   logic [SLOT_W-1:0] p_ff, p_in;
   logic [SLOT_W-1:0] cur_ff, cur_in;
   logic              pend_ff, pend_in;
   logic [POS_W-1:0]  steps_ff, steps_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [DATA_W-1:0] rsp_read_ff, rsp_read_in;
   logic [LEN_W-1:0]  rsp_len_ff, rsp_len_in;

   logic              req_fire;
   logic              rsp_load;
   logic [STAT_W-1:0] req_status;
   logic [SLOT_W-1:0] cur_now;
   logic              pos_zero;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_RESPOND) && (!rsp_valid_ff || rsp_ready);
   assign pos_zero  = (pos_ff == '0);

   // Current walk slot: fresh link data while a hop is in flight
   assign cur_now = pend_ff ? link_rd_data : cur_ff;

   // Check the request against the list length
   always_comb begin
      case (req_cmd)
         CMD_INSERT: begin
            if (LEN_W'(req_position) > count_ff) begin
               req_status = STAT_RANGE;
            end else if (count_ff == LEN_W'(CAPACITY)) begin
               req_status = STAT_FULL;
            end else begin
               req_status = STAT_OK;
            end
         end
         CMD_DELETE, CMD_READ: begin
            req_status = (LEN_W'(req_position) >= count_ff) ? STAT_RANGE : STAT_OK;
         end
         default: req_status = STAT_OK;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_status != STAT_OK) begin
                  state_in = ST_RESPOND;
               end else begin
                  case (req_cmd)
                     CMD_INSERT: state_in = ST_INS_FREE;
                     CMD_DELETE: state_in = (req_position == '0) ? ST_DEL_HEAD : ST_WALK;
                     CMD_READ:   state_in = ST_WALK;
                     default:    state_in = ST_RESPOND;
                  endcase
               end
            end
         end
         ST_INS_FREE:   state_in = ST_INS_TAKE;
         ST_INS_TAKE:   state_in = pos_zero ? ST_RESPOND : ST_WALK;
         ST_WALK: begin
            if (steps_ff == '0) begin
               case (cmd_ff)
                  CMD_INSERT: state_in = ST_INS_LINK;
                  CMD_DELETE: state_in = ST_DEL_NEXT;
                  default:    state_in = ST_RD_DATA;
               endcase
            end
         end
         ST_INS_LINK:   state_in = ST_INS_FIX;
         ST_INS_FIX:    state_in = ST_RESPOND;
         ST_DEL_HEAD:   state_in = ST_DEL_UNLINK;
         ST_DEL_NEXT:   state_in = ST_DEL_UNLINK;
         ST_DEL_UNLINK: state_in = ST_DEL_FREE;
         ST_DEL_FREE:   state_in = ST_RESPOND;
         ST_RD_DATA:    state_in = ST_RESPOND;
         ST_RESPOND: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:       state_in = ST_IDLE;
      endcase
   end

   // Memory reads and writes per state
   always_comb begin
      link_rd_addr  = cur_now;
      value_rd_addr = cur_now;
      link_wr       = '0;
      value_wr      = '0;
      case (state_ff)
         ST_INS_FREE: link_rd_addr = free_ff;
         ST_INS_TAKE: begin
            value_wr.en   = 1'b1;
            value_wr.addr = s_ff;
            value_wr.data = val_ff;
            if (pos_zero) begin
               link_wr.en   = 1'b1;
               link_wr.addr = s_ff;
               link_wr.data = first_ff;
            end
         end
         ST_INS_LINK: begin
            link_wr.en   = 1'b1;
            link_wr.addr = s_ff;
            link_wr.data = link_rd_data;
         end
         ST_INS_FIX: begin
            link_wr.en   = 1'b1;
            link_wr.addr = p_ff;
            link_wr.data = s_ff;
         end
         ST_DEL_HEAD: link_rd_addr = first_ff;
         ST_DEL_NEXT: link_rd_addr = link_rd_data;
         ST_DEL_UNLINK: begin
            if (!pos_zero) begin
               link_wr.en   = 1'b1;
               link_wr.addr = p_ff;
               link_wr.data = link_rd_data;
            end
         end
         ST_DEL_FREE: begin
            link_wr.en   = 1'b1;
            link_wr.addr = s_ff;
            link_wr.data = free_ff;
         end
         default: begin
            link_wr  = '0;
            value_wr = '0;
         end
      endcase
   end

   // Datapath and list head updates
   always_comb begin
      cmd_in        = cmd_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      status_in     = status_ff;
      rdv_in        = rdv_ff;
      first_in      = first_ff;
      free_in       = free_ff;
      count_in      = count_ff;
      s_in          = s_ff;
      p_in          = p_ff;
      cur_in        = cur_ff;
      pend_in       = pend_ff;
      steps_in      = steps_ff;
      rsp_status_in = rsp_status_ff;
      rsp_read_in   = rsp_read_ff;
      rsp_len_in    = rsp_len_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in    = req_cmd;
               pos_in    = req_position;
               val_in    = req_value;
               status_in = req_status;
               rdv_in    = '0;
               s_in      = (req_cmd == CMD_DELETE) ? first_ff : free_ff;
               cur_in    = first_ff;
               pend_in   = 1'b0;
               steps_in  = (req_cmd == CMD_READ) ? req_position
                                                 : req_position - POS_W'(1);
            end
         end
         ST_INS_TAKE: begin
            free_in = link_rd_data;
            if (pos_zero) begin
               first_in = s_ff;
               count_in = count_ff + LEN_W'(1);
            end
         end
         ST_WALK: begin
            cur_in = cur_now;
            p_in   = cur_now;
            if (steps_ff != '0) begin
               pend_in  = 1'b1;
               steps_in = steps_ff - POS_W'(1);
            end else begin
               pend_in = 1'b0;
            end
         end
         ST_INS_FIX: count_in = count_ff + LEN_W'(1);
         ST_DEL_NEXT: s_in = link_rd_data;
         ST_DEL_UNLINK: begin
            if (pos_zero) begin
               first_in = link_rd_data;
            end
         end
         ST_DEL_FREE: begin
            free_in  = s_ff;
            count_in = count_ff - LEN_W'(1);
         end
         ST_RD_DATA: rdv_in = value_rd_data;
         ST_RESPOND: begin
            if (rsp_load) begin
               rsp_status_in = status_ff;
               rsp_read_in   = rdv_ff;
               rsp_len_in    = count_ff;
            end
         end
         default: cmd_in = cmd_ff;
      endcase
   end

   // Response valid: set on load, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         first_ff     <= '0;
         free_ff      <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         first_ff     <= first_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      status_ff     <= status_in;
      rdv_ff        <= rdv_in;
      s_ff          <= s_in;
      p_ff          <= p_in;
      cur_ff        <= cur_in;
      steps_ff      <= steps_in;
      rsp_status_ff <= rsp_status_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_ff;
   assign rsp_length     = rsp_len_ff;

   // Length never exceeds the capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LEN_W'(CAPACITY))
      else $error("entry count above capacity");

   // A slot is taken from the free chain only when one is left
   a_take_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_TAKE) |-> (count_ff < LEN_W'(CAPACITY)))
      else $error("slot taken from an empty free chain");

   // A slot is returned only while the list holds an entry
   a_free_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEL_FREE) |-> (count_ff != '0))
      else $error("slot freed from an empty list");

   // A new response appears only out of the respond state
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_RESPOND))
      else $error("response raised outside respond state");

   // Length holds across a cycle spent idle
   a_idle_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |=> $stable(count_ff))
      else $error("length changed from idle");

endmodule

FILE: rtl/positional_list_engine_unit.sv
// Top level of the positional list engine: sequencer plus link and value memories.
//
//   channel   direction   carries
//   req_bus   in          cmd, position, value
//   rsp_bus   out         status, read_value, length
//
// One request at a time. A rejected or unknown command goes straight to its
// response; a read, a delete or an insert walks to its position (an insert or
// a delete at the front does not): the walk follows one link per cycle
// through the link memory's single read port.
// Reset is synchronous; the link memory reads as the full free chain at once.
// A response waits in its output register while the next request is taken;
// a stall on rsp_bus holds the sequencer only once its next response is ready.
`timescale 1ns / 1ps

module positional_list_engine_unit import ple_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   ple_req_if.sink   req_bus,
   ple_rsp_if.source rsp_bus
);

   logic [SLOT_W-1:0] link_rd_addr;
   logic [SLOT_W-1:0] link_rd_data;
   link_wr_type       link_wr;
   logic [SLOT_W-1:0] value_rd_addr;
   logic [DATA_W-1:0] value_rd_data;
   value_wr_type      value_wr;
   logic [DATA_W-1:0] rsp_read_value;

   ple_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_bus.valid),
      .req_ready      (req_bus.ready),
      .req_cmd        (req_bus.cmd),
      .req_position   (req_bus.position),
      .req_value      (req_bus.value),
      .rsp_valid      (rsp_bus.valid),
      .rsp_ready      (rsp_bus.ready),
      .rsp_status     (rsp_bus.status),
      .rsp_read_value (rsp_read_value),
      .rsp_length     (rsp_bus.length),
      .link_rd_addr   (link_rd_addr),
      .link_rd_data   (link_rd_data),
      .link_wr        (link_wr),
      .value_rd_addr  (value_rd_addr),
      .value_rd_data  (value_rd_data),
      .value_wr       (value_wr)
   );

   assign rsp_bus.read_value = rsp_read_value;

   ple_link_ram u_link_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (link_rd_addr),
      .rd_data (link_rd_data),
      .wr      (link_wr)
   );

   ple_value_ram u_value_ram (
      .clock   (clock),
      .rd_addr (value_rd_addr),
      .rd_data (value_rd_data),
      .wr      (value_wr)
   );

endmodule
